// ----- rtl/cdu_pkg.sv -----
// Package for the complex divider unit: widths, request/result payload types
// and the sideband struct that travels with each item. No dependencies.
`default_nettype none
package cdu_pkg;

  localparam int OPERAND_WIDTH          = 16;
  localparam int PROD_WIDTH             = 2 * OPERAND_WIDTH;
  localparam int QUOTIENT_WIDTH         = 32;
  localparam int QUOTIENT_FRACTION_BITS = 16;

  typedef struct packed {
    logic signed [OPERAND_WIDTH-1:0] dividend_real;
    logic signed [OPERAND_WIDTH-1:0] dividend_imag;
    logic signed [OPERAND_WIDTH-1:0] divisor_real;
    logic signed [OPERAND_WIDTH-1:0] divisor_imag;
  } request_t;

  typedef struct packed {
    logic signed [QUOTIENT_WIDTH-1:0] quotient_real;
    logic signed [QUOTIENT_WIDTH-1:0] quotient_imag;
    logic                             divide_by_zero;
    logic                             saturated;
  } result_t;

  // Control carried alongside the data from the last front-end stage through every divider stage.
  typedef struct packed {
    logic valid;
    logic dz;
    logic neg_re;
    logic neg_im;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/complex_divider_unit.sv -----
// Top level of the complex divider: front end, pipelined divider and the
// saturating output stage. Uses cdu_pkg, cdu_front, cdu_divider.
`default_nettype none
// Divides (a+bi) by (c+di) and returns both quotient parts as signed Q16.16
// (QUOTIENT_FRACTION_BITS fraction bits), truncated toward zero. A request is
// taken on any cycle start is high; busy is always low, so one request per
// cycle is sustained. The result appears with done high for exactly one cycle,
// after the request has passed through three front-end stages (products, sums,
// magnitudes), one restoring-division stage per quotient bit, and one output
// stage. Results leave in request order and cannot be held off. A zero
// divisor gives divide_by_zero with zero quotients; a quotient beyond the
// 32-bit range is clamped and sets saturated.
module complex_divider_unit #(
  parameter int QUOTIENT_FRACTION_BITS = cdu_pkg::QUOTIENT_FRACTION_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire cdu_pkg::request_t request,
  output logic                   done,
  output cdu_pkg::result_t       result
);

  localparam int NW  = cdu_pkg::PROD_WIDTH;
  localparam int QW  = NW + QUOTIENT_FRACTION_BITS;
  localparam int OW  = cdu_pkg::QUOTIENT_WIDTH;
  localparam int LAT = QW + 4;

  // clamp points, as magnitudes
  localparam logic [QW-1:0] LIM_POS = QW'({1'b0, {(OW-1){1'b1}}});
  localparam logic [QW-1:0] LIM_NEG = QW'({1'b1, {(OW-1){1'b0}}});

  cdu_pkg::side_t       f_side, d_side;
  logic [NW-1:0]        num_re, num_im, den;
  logic [QW-1:0]        q_re, q_im;
  logic                 sat_re, sat_im;
  logic [OW-1:0]        res_re, res_im;

  // fully pipelined: never stalls
  assign busy = 1'b0;

  cdu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .req      (request),
    .side     (f_side),
    .num_re   (num_re),
    .num_im   (num_im),
    .den      (den)
  );

  cdu_divider #(
    .FRAC (QUOTIENT_FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_side  (f_side),
    .num_re   (num_re),
    .num_im   (num_im),
    .den      (den),
    .out_side (d_side),
    .q_re     (q_re),
    .q_im     (q_im)
  );

  // Saturate against the sign-dependent limit, then restore the sign.
  always_comb begin
    sat_re = d_side.neg_re ? (q_re > LIM_NEG) : (q_re > LIM_POS);
    sat_im = d_side.neg_im ? (q_im > LIM_NEG) : (q_im > LIM_POS);
    if (sat_re) begin
      res_re = d_side.neg_re ? LIM_NEG[OW-1:0] : LIM_POS[OW-1:0];
    end else begin
      res_re = d_side.neg_re ? OW'(-q_re[OW-1:0]) : q_re[OW-1:0];
    end
    if (sat_im) begin
      res_im = d_side.neg_im ? LIM_NEG[OW-1:0] : LIM_POS[OW-1:0];
    end else begin
      res_im = d_side.neg_im ? OW'(-q_im[OW-1:0]) : q_im[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_side.dz) begin
      result.quotient_real  <= '0;
      result.quotient_imag  <= '0;
      result.divide_by_zero <= 1'b1;
      result.saturated      <= 1'b0;
    end else begin
      result.quotient_real  <= res_re;
      result.quotient_imag  <= res_im;
      result.divide_by_zero <= 1'b0;
      result.saturated      <= sat_re | sat_im;
    end
  end

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching request");

  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    (done && result.divide_by_zero) |->
      (result.quotient_real == '0 && result.quotient_imag == '0 && !result.saturated))
    else $error("divide by zero with nonzero output");

  a_sat_clamp : assert property (@(posedge clk) disable iff (rst)
    (done && result.saturated) |->
      (result.quotient_real == LIM_POS[OW-1:0] || result.quotient_real == LIM_NEG[OW-1:0] ||
       result.quotient_imag == LIM_POS[OW-1:0] || result.quotient_imag == LIM_NEG[OW-1:0]))
    else $error("saturated without a clamped part");
`endif

endmodule
`default_nettype wire

// ----- rtl/cdu_front.sv -----
// Front end of the complex divider: products, numerator/denominator sums and
// sign-magnitude split, three register stages. Uses cdu_pkg.
`default_nettype none
module cdu_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire cdu_pkg::request_t              req,
  output cdu_pkg::side_t                      side,
  output logic [cdu_pkg::PROD_WIDTH-1:0]      num_re,
  output logic [cdu_pkg::PROD_WIDTH-1:0]      num_im,
  output logic [cdu_pkg::PROD_WIDTH-1:0]      den
);

  localparam int PW = cdu_pkg::PROD_WIDTH;

  // stage 1: four cross products and two squares
  logic               v1;
  logic signed [PW-1:0] ac, bd, bc, ad, cc, dd;
  // stage 2: sums
  logic               v2;
  logic signed [PW:0] nre, nim;
  logic [PW-1:0]      den2;
  // stage 3: magnitudes, valid travels in side

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      side.valid <= 1'b0;
    end else begin
      v1         <= in_valid;
      v2         <= v1;
      side.valid <= v2;
    end

    ac <= req.dividend_real * req.divisor_real;
    bd <= req.dividend_imag * req.divisor_imag;
    bc <= req.dividend_imag * req.divisor_real;
    ad <= req.dividend_real * req.divisor_imag;
    cc <= req.divisor_real * req.divisor_real;
    dd <= req.divisor_imag * req.divisor_imag;

    nre  <= {ac[PW-1], ac} + {bd[PW-1], bd};
    nim  <= {bc[PW-1], bc} - {ad[PW-1], ad};
    den2 <= $unsigned(cc) + $unsigned(dd);

    side.neg_re <= nre[PW];
    side.neg_im <= nim[PW];
    num_re      <= nre[PW] ? PW'(-nre) : nre[PW-1:0];
    num_im      <= nim[PW] ? PW'(-nim) : nim[PW-1:0];
    side.dz     <= (den2 == '0);
    den         <= den2;
  end

endmodule
`default_nettype wire

// ----- rtl/cdu_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one denominator. Uses cdu_pkg.
`default_nettype none
module cdu_divider #(
  parameter int FRAC = cdu_pkg::QUOTIENT_FRACTION_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire cdu_pkg::side_t                            in_side,
  input  wire logic [cdu_pkg::PROD_WIDTH-1:0]            num_re,
  input  wire logic [cdu_pkg::PROD_WIDTH-1:0]            num_im,
  input  wire logic [cdu_pkg::PROD_WIDTH-1:0]            den,
  output cdu_pkg::side_t                                 out_side,
  output logic [cdu_pkg::PROD_WIDTH+FRAC-1:0]            q_re,
  output logic [cdu_pkg::PROD_WIDTH+FRAC-1:0]            q_im
);

  localparam int NW = cdu_pkg::PROD_WIDTH;
  localparam int QW = NW + FRAC;

  // Work word: dividend bits shift out the top, quotient bits shift in below.
  cdu_pkg::side_t    sd   [0:QW];
  logic [NW-1:0]     rre  [0:QW];
  logic [NW-1:0]     rim  [0:QW];
  logic [QW-1:0]     wre  [0:QW];
  logic [QW-1:0]     wim  [0:QW];
  logic [NW-1:0]     dn   [0:QW];

  assign sd[0]  = in_side;
  assign rre[0] = '0;
  assign rim[0] = '0;
  assign wre[0] = QW'(num_re) << FRAC;
  assign wim[0] = QW'(num_im) << FRAC;
  assign dn[0]  = den;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW:0] sh_re, sh_im;
    logic        ge_re, ge_im;

    always_comb begin
      sh_re = {rre[i], wre[i][QW-1]};
      sh_im = {rim[i], wim[i][QW-1]};
      ge_re = (sh_re >= {1'b0, dn[i]});
      ge_im = (sh_im >= {1'b0, dn[i]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1].valid <= 1'b0;
      end else begin
        sd[i+1].valid <= sd[i].valid;
      end
      sd[i+1].dz     <= sd[i].dz;
      sd[i+1].neg_re <= sd[i].neg_re;
      sd[i+1].neg_im <= sd[i].neg_im;
      dn[i+1]        <= dn[i];
      rre[i+1] <= ge_re ? NW'(sh_re - {1'b0, dn[i]}) : sh_re[NW-1:0];
      rim[i+1] <= ge_im ? NW'(sh_im - {1'b0, dn[i]}) : sh_im[NW-1:0];
      wre[i+1] <= {wre[i][QW-2:0], ge_re};
      wim[i+1] <= {wim[i][QW-2:0], ge_im};
    end
  end

  assign out_side = sd[QW];
  assign q_re     = wre[QW];
  assign q_im     = wim[QW];

endmodule
`default_nettype wire

// ----- dv/tb_complex_divider_unit.sv -----
// Self-checking testbench for complex_divider_unit: drives division requests,
// predicts each quotient and compares results in order. Depends on cdu_pkg.
`default_nettype none
module tb_complex_divider_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY      = cdu_pkg::PROD_WIDTH + cdu_pkg::QUOTIENT_FRACTION_BITS + 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_COUNT = 1800;

  // Quotient predictor and in-order store of expected results.
  class quotient_board;
    cdu_pkg::result_t pending_quotients[$];
    int               mismatches;

    // Signed fixed-point divide, truncated toward zero, clamped to 32 bits.
    static function logic [31:0] fx_quotient(longint num, longint den, ref bit sat);
      longint          mag;
      longint          q;
      longint          limit;
      logic [63:0]     wide;
      mag   = (num < 0) ? -num : num;
      limit = (num < 0) ? 64'sh80000000 : 64'sh7FFFFFFF;
      wide  = 64'(mag) << cdu_pkg::QUOTIENT_FRACTION_BITS;
      q     = longint'(wide / 64'(den));
      if (q > limit) begin
        q   = limit;
        sat = 1'b1;
      end
      return (num < 0) ? 32'(-q) : 32'(q);
    endfunction

    function void note_request(cdu_pkg::request_t req);
      longint           a, b, c, d, den;
      bit               sat;
      cdu_pkg::result_t exp_res;
      a = req.dividend_real;
      b = req.dividend_imag;
      c = req.divisor_real;
      d = req.divisor_imag;
      den = c * c + d * d;
      sat = 1'b0;
      exp_res = '0;
      if (den == 0) begin
        exp_res.divide_by_zero = 1'b1;
      end else begin
        exp_res.quotient_real = fx_quotient(a * c + b * d, den, sat);
        exp_res.quotient_imag = fx_quotient(b * c - a * d, den, sat);
        exp_res.saturated     = sat;
      end
      pending_quotients.push_back(exp_res);
    endfunction

    function void check_result(cdu_pkg::result_t got);
      cdu_pkg::result_t exp_res;
      if (pending_quotients.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
        return;
      end
      exp_res = pending_quotients.pop_front();
      if (got.quotient_real !== exp_res.quotient_real)
        report_mismatch("quotient_real", got.quotient_real, exp_res.quotient_real);
      if (got.quotient_imag !== exp_res.quotient_imag)
        report_mismatch("quotient_imag", got.quotient_imag, exp_res.quotient_imag);
      if (got.divide_by_zero !== exp_res.divide_by_zero)
        report_mismatch("divide_by_zero", got.divide_by_zero, exp_res.divide_by_zero);
      if (got.saturated !== exp_res.saturated)
        report_mismatch("saturated", got.saturated, exp_res.saturated);
    endfunction

    function void report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  cdu_pkg::request_t request = '0;
  logic              done;
  cdu_pkg::result_t  result;

  quotient_board board = new();
  int idle_pct = 0;
  int stall_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  complex_divider_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  // Requests and results are sampled at the edge; the predictor sees requests
  // in acceptance order, so the queue lines up with the pipeline.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_request(request);
      if (done) board.check_result(result);
      stall_cycles <= (start && !busy) || done ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: no traffic for too long ends the run.
  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sends one request; holds start high until it is taken. Random gaps first.
  task automatic send_division(cdu_pkg::request_t req);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random operand biased toward extremes and small values.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    cdu_pkg::request_t req;
    repeat (count) begin
      req.dividend_real = pick_operand();
      req.dividend_imag = ($urandom_range(7) == 0) ? 16'h0 : pick_operand();
      req.divisor_real  = pick_operand();
      req.divisor_imag  = ($urandom_range(7) == 0) ? 16'h0 : pick_operand();
      send_division(req);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero divisor, extremes, real-only operands, saturation.
    send_division('{16'sd5, 16'sd3, 16'sd0, 16'sd0});
    send_division('{-16'sd32768, -16'sd32768, 16'sd0, 16'sd0});
    send_division('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_division('{16'sd7, 16'sd0, 16'sd2, 16'sd0});
    send_division('{-16'sd7, 16'sd0, 16'sd2, 16'sd0});
    send_division('{16'sd1, 16'sd1, 16'sd1, 16'sd1});
    send_division('{16'sd1, 16'sd0, 16'sd3, 16'sd0});
    send_division('{-16'sd1, 16'sd0, 16'sd3, 16'sd0});
    send_division('{16'sd32767, 16'sd32767, 16'sd1, 16'sd0});
    send_division('{-16'sd32768, -16'sd32768, 16'sd1, 16'sd0});
    send_division('{16'sd32767, -16'sd32768, 16'sd0, 16'sd1});
    send_division('{-16'sd32768, 16'sd0, -16'sd1, 16'sd0});
    send_division('{-16'sd32768, 16'sd32767, 16'sd1, -16'sd1});
    send_division('{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768});
    send_division('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    send_division('{16'sd1, 16'sd0, 16'sd32767, 16'sd32767});
    send_division('{16'sd16384, 16'sd0, 16'sd1, 16'sd0});
    send_division('{-16'sd16384, 16'sd0, 16'sd1, 16'sd0});
    send_division('{16'sd0, 16'sd5, 16'sd0, -16'sd2});
    send_division('{16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA});

    // Random: sender idles 31%, then 51%, then back to back.
    idle_pct = 31;
    send_random(RANDOM_COUNT / 3);
    idle_pct = 51;
    send_random(RANDOM_COUNT / 3);
    idle_pct = 0;
    send_random(RANDOM_COUNT / 3);
    start <= 1'b0;

    while (board.pending_quotients.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (board.mismatches == 0 && board.pending_quotients.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- complex_divider_unit.f -----
rtl/cdu_pkg.sv
rtl/cdu_front.sv
rtl/cdu_divider.sv
rtl/complex_divider_unit.sv
dv/tb_complex_divider_unit.sv
